// File: src/sucs_pkg.sv
// Shared types, codes and constants of the smoothed unigram cell scorer.
`timescale 1ns / 1ps
package sucs_pkg;

  localparam int CELL_REQ_W = 11;
  localparam int WORD_W     = 10;
  localparam int WEIGHT_W   = 16;
  localparam int TOTAL_W    = 32;
  localparam int LN_W       = 24;
  localparam int P_W        = 49;
  localparam int MANT_W     = 31;
  localparam int FRAC_W     = 20;
  localparam int SQ_STEPS   = 20;

  localparam logic [WEIGHT_W-1:0] CELL_WEIGHT_RST   = 16'd59578;
  localparam logic [WEIGHT_W-1:0] GLOBAL_WEIGHT_RST = 16'd5958;
  localparam logic [31:0]         LN2_Q32           = 32'd2977044472;
  localparam logic [LN_W-1:0]     MEAN_MIN          = 24'h800000;

  localparam logic [1:0] CMD_TRAIN  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_SCORE  = 2'd3;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_EMPTY_QUERY = 2'd1;
  localparam logic [1:0] STAT_EMPTY_MODEL = 2'd2;
  localparam logic [1:0] STAT_DROPPED     = 2'd3;

  localparam logic REG_CELL_WEIGHT   = 1'b0;
  localparam logic REG_GLOBAL_WEIGHT = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_TRAIN_RD, ST_TRAIN_WR, ST_SC_START, ST_SC_N,
    ST_SC_QRD, ST_SC_QW, ST_SC_CA, ST_SC_DIV, ST_SC_MUL, ST_SC_SUM,
    ST_SC_LOG, ST_SC_NEXT, ST_SC_MEAN, ST_SC_MWAIT, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    LG_IDLE, LG_NORM, LG_MUL, LG_CHK, LG_SCALE, LG_ROUND
  } log_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// File: src/sucs_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sucs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                     wdata,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: src/sucs_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sucs_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] rem_init,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, quot[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      quot  <= num;
      den_q <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end
endmodule

// File: src/sucs_log.sv
// Natural log unit: normalize, square twenty times, scale by ln 2 and round.
`timescale 1ns / 1ps
module sucs_log (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sucs_pkg::P_W-1:0]         p,
  output logic                             done,
  output logic signed [sucs_pkg::LN_W-1:0] ln
);
  import sucs_pkg::*;

  log_state_t state, state_next;

  logic [P_W-1:0]    v;
  logic [5:0]        e;
  logic [MANT_W-1:0] m;
  logic [2*MANT_W-1:0] sq;
  logic [FRAC_W-1:0] f;
  logic [4:0]        step;
  logic [25:0]       mag_l;
  logic [57:0]       prod;
  logic [58:0]       rounded;
  logic              neg;
  logic [31:0]       t;
  logic              last_step;

  always_comb begin
    state_next = state;
    unique case (state)
      LG_IDLE:  if (start) state_next = LG_NORM;
      LG_NORM:  if (v[P_W-1]) state_next = LG_MUL;
      LG_MUL:   state_next = LG_CHK;
      LG_CHK:   state_next = last_step ? LG_SCALE : LG_MUL;
      LG_SCALE: state_next = LG_ROUND;
      LG_ROUND: state_next = LG_IDLE;
      default:  state_next = LG_IDLE;
    endcase
  end

  always_comb begin
    t         = sq[2*MANT_W-1:MANT_W-1];
    last_step = step == 5'(SQ_STEPS - 1);
    if (e == 6'(P_W - 1)) begin
      mag_l = 26'(f);
    end else begin
      mag_l = {6'(6'(P_W - 1) - e), 20'd0} - 26'(f);
    end
    rounded = {1'b0, prod} + (59'd1 << 35);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == LG_ROUND;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      LG_IDLE: begin
        v <= p;
        e <= 6'(P_W - 1);
      end
      LG_NORM: begin
        step <= '0;
        f    <= '0;
        m    <= v[P_W-1 -: MANT_W];
        if (!v[P_W-1]) begin
          v <= {v[P_W-2:0], 1'b0};
          e <= e - 1'b1;
        end
      end
      LG_MUL: sq <= m * m;
      LG_CHK: begin
        step <= step + 1'b1;
        if (t[31]) begin
          m <= t[31:1];
          f <= {f[FRAC_W-2:0], 1'b1};
        end else begin
          m <= t[MANT_W-1:0];
          f <= {f[FRAC_W-2:0], 1'b0};
        end
      end
      LG_SCALE: begin
        prod <= mag_l * LN2_Q32;
        neg  <= e != 6'(P_W - 1);
      end
      LG_ROUND: ln <= neg ? -LN_W'(rounded[58:36]) : LN_W'(rounded[58:36]);
      default: ;
    endcase
  end
endmodule

// File: src/smoothed_unigram_cell_scorer.sv
// Top level of the smoothed unigram cell scorer.
//
// Items enter on item_valid/item_stall with command, cell_req and word.
// Train adds one count for a (cell, word) pair. Append and clear of the
// query buffer act when the item is accepted. Score walks the query buffer
// one word at a time and returns one item on res_valid/res_stall.
// For each query word the two ratio dividers run in parallel, then the log
// unit normalizes by shifting, squares twenty times, scales by ln 2 and
// rounds, unless the probability sum is zero. The final mean is then formed
// on the serial divider. After reset the block sweeps the count and total
// memories to zero, one entry per cycle over all
// 2^(clog2(NUM_CELLS)+clog2(NUM_WORDS)) count entries, 2,097,152 at the
// defaults; item_stall stays high meanwhile. Configuration writes are
// always taken. A finished score waits in the DONE state while the receiver
// stalls the output register; no new items are accepted then.
`timescale 1ns / 1ps
module smoothed_unigram_cell_scorer #(
  parameter int NUM_CELLS   = 2048,
  parameter int NUM_WORDS   = 1024,
  parameter int MAX_QUERY   = 64,
  parameter int COUNT_WIDTH = 20
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [1:0]                             command,
  input  logic [sucs_pkg::CELL_REQ_W-1:0]        cell_req,
  input  logic [sucs_pkg::WORD_W-1:0]            word,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic [sucs_pkg::CELL_REQ_W-1:0]        scored_cell,
  output logic signed [sucs_pkg::LN_W-1:0]       mean_log_prob,
  output logic [1:0]                             status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [sucs_pkg::WEIGHT_W-1:0]          cfg_data
);
  import sucs_pkg::*;

  localparam int CW     = $clog2(NUM_CELLS);
  localparam int WW     = $clog2(NUM_WORDS);
  localparam int TAW    = CW + WW;
  localparam int QAW    = MAX_QUERY > 1 ? $clog2(MAX_QUERY) : 1;
  localparam int QLW    = $clog2(MAX_QUERY + 1);
  localparam int SUM_W  = LN_W + QLW + 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t state, state_next;

  logic [WEIGHT_W-1:0]    cell_w, global_w;
  logic [CELL_REQ_W-1:0]  cell_q;
  logic [WORD_W-1:0]      word_q, qword_q;
  logic [TOTAL_W-1:0]     global_total;
  logic [QLW-1:0]         qlen, qi;
  logic                   dropped;
  logic [TAW-1:0]         clr_cnt;
  logic [TOTAL_W-1:0]     n_q;
  logic                   cap_c, cap_g, n_nz;
  logic [P_W-1:0]         prod_c, prod_g, p_sum;
  logic signed [SUM_W-1:0] acc;
  logic [SUM_W-1:0]       acc_mag;
  logic signed [LN_W-1:0] mean_q;
  logic [1:0]             status_q;

  logic                   accept;
  logic [CW-1:0]          cell_idx;
  logic [WW-1:0]          word_idx, qword_idx;
  logic                   cell_ok, word_ok, qword_ok, train_go;

  logic [TAW-1:0]         cnt_addr;
  logic                   cnt_we;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rd;
  logic [CW-1:0]          ct_addr;
  logic                   ct_we;
  logic [TOTAL_W-1:0]     ct_wdata, ct_rd;
  logic [WW-1:0]          wt_addr;
  logic                   wt_we;
  logic [TOTAL_W-1:0]     wt_wdata, wt_rd;
  logic [QAW-1:0]         q_addr;
  logic                   q_we;
  logic [WORD_W-1:0]      q_rd;

  logic [TOTAL_W-1:0]     c_val, a_val, xc, xg;
  logic                   divc_start, divc_done, divg_start, divg_done;
  logic                   mdiv_start, mdiv_done, log_start, log_done;
  logic [TOTAL_W-1:0]     qc, qg;
  logic [TOTAL_W:0]       rc, rg;
  logic [SUM_W-1:0]       mquot;
  logic signed [LN_W-1:0] ln_val;
  logic signed [LN_W-1:0] mean_calc;
  logic                   out_free;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && !item_stall;
  assign out_free  = !res_valid || !res_stall;

  assign cell_idx  = 32'(cell_q) < NUM_CELLS ? CW'(32'(cell_q)) : '0;
  assign word_idx  = WW'(32'(word_q));
  assign qword_idx = WW'(32'(q_rd));
  assign cell_ok   = 32'(cell_q) < NUM_CELLS;
  assign word_ok   = 32'(word_q) < NUM_WORDS;
  assign qword_ok  = 32'(qword_q) < NUM_WORDS;
  assign train_go  = cell_ok && word_ok && (cnt_rd != COUNT_MAX);

  always_comb begin
    c_val = (qword_ok && cell_ok) ? 32'(cnt_rd) : '0;
    a_val = qword_ok ? wt_rd : '0;
    xc    = (c_val == '0 && a_val == '0) ? 32'd1 : c_val;
    xg    = (a_val == '0 && (n_q == '0 || c_val == '0)) ? 32'd1 : a_val;
    rc    = cap_c ? {1'b1, 32'd0} : {1'b0, qc};
    rg    = cap_g ? {1'b1, 32'd0} : {1'b0, qg};
    p_sum = prod_c + prod_g;
    acc_mag = acc[SUM_W-1] ? SUM_W'(-acc) : SUM_W'(acc);
    if (!acc[SUM_W-1]) begin
      mean_calc = '0;
    end else if (|mquot[SUM_W-1:LN_W-1]) begin
      mean_calc = MEAN_MIN;
    end else begin
      mean_calc = -LN_W'(mquot);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (&clr_cnt) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept && command == CMD_TRAIN) state_next = ST_TRAIN_RD;
        if (accept && command == CMD_SCORE) state_next = ST_SC_START;
      end
      ST_TRAIN_RD: state_next = ST_TRAIN_WR;
      ST_TRAIN_WR: state_next = ST_IDLE;
      ST_SC_START: begin
        state_next = (qlen == '0 || global_total == '0) ? ST_DONE : ST_SC_N;
      end
      ST_SC_N:   state_next = ST_SC_QRD;
      ST_SC_QRD: state_next = ST_SC_QW;
      ST_SC_QW:  state_next = ST_SC_CA;
      ST_SC_CA:  state_next = ST_SC_DIV;
      ST_SC_DIV: if (divc_done) state_next = ST_SC_MUL;
      ST_SC_MUL: state_next = ST_SC_SUM;
      ST_SC_SUM: state_next = (p_sum == '0) ? ST_SC_NEXT : ST_SC_LOG;
      ST_SC_LOG: if (log_done) state_next = ST_SC_NEXT;
      ST_SC_NEXT: state_next = (qi + 1'b1 == qlen) ? ST_SC_MEAN : ST_SC_QRD;
      ST_SC_MEAN:  state_next = ST_SC_MWAIT;
      ST_SC_MWAIT: if (mdiv_done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = state != ST_IDLE;
    cnt_addr   = {cell_idx, word_idx};
    cnt_we     = 1'b0;
    cnt_wdata  = cnt_rd + 1'b1;
    ct_addr    = cell_idx;
    ct_we      = 1'b0;
    ct_wdata   = sat_inc(ct_rd);
    wt_addr    = word_idx;
    wt_we      = 1'b0;
    wt_wdata   = sat_inc(wt_rd);
    q_addr     = QAW'(qi);
    q_we       = 1'b0;
    divc_start = 1'b0;
    divg_start = 1'b0;
    mdiv_start = 1'b0;
    log_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cnt_addr  = clr_cnt;
        cnt_we    = 1'b1;
        cnt_wdata = '0;
        ct_addr   = clr_cnt[CW-1:0];
        ct_we     = clr_cnt[TAW-1:CW] == '0;
        ct_wdata  = '0;
        wt_addr   = clr_cnt[WW-1:0];
        wt_we     = clr_cnt[TAW-1:WW] == '0;
        wt_wdata  = '0;
      end
      ST_IDLE: begin
        q_addr = QAW'(qlen);
        q_we   = accept && command == CMD_APPEND && qlen < QLW'(MAX_QUERY);
      end
      ST_TRAIN_WR: begin
        cnt_we = train_go;
        ct_we  = train_go;
        wt_we  = train_go;
      end
      ST_SC_QW: begin
        cnt_addr = {cell_idx, qword_idx};
        wt_addr  = qword_idx;
      end
      ST_SC_CA: begin
        divc_start = 1'b1;
        divg_start = 1'b1;
      end
      ST_SC_SUM:  log_start  = p_sum != '0;
      ST_SC_MEAN: mdiv_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      global_total <= '0;
      qlen         <= '0;
      dropped      <= 1'b0;
      res_valid    <= 1'b0;
      cell_w       <= CELL_WEIGHT_RST;
      global_w     <= GLOBAL_WEIGHT_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CELL_WEIGHT:   cell_w   <= cfg_data;
          REG_GLOBAL_WEIGHT: global_w <= cfg_data;
          default: ;
        endcase
      end
      if (accept && command == CMD_APPEND) begin
        if (qlen < QLW'(MAX_QUERY)) begin
          qlen <= qlen + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (accept && command == CMD_CLEAR) begin
        qlen    <= '0;
        dropped <= 1'b0;
      end
      if (state == ST_TRAIN_WR && train_go) begin
        global_total <= sat_inc(global_total);
      end
      if (state == ST_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_q <= cell_req;
      word_q <= word;
    end
    unique case (state)
      ST_SC_START: begin
        qi       <= '0;
        acc      <= '0;
        mean_q   <= '0;
        status_q <= (qlen == '0) ? STAT_EMPTY_QUERY : STAT_EMPTY_MODEL;
      end
      ST_SC_N: n_q <= cell_ok ? ct_rd : '0;
      ST_SC_QW: qword_q <= q_rd;
      ST_SC_CA: begin
        n_nz  <= n_q != '0;
        cap_c <= xc >= n_q;
        cap_g <= xg >= global_total;
      end
      ST_SC_MUL: begin
        prod_c <= n_nz ? cell_w * rc : '0;
        prod_g <= global_w * rg;
      end
      ST_SC_SUM: begin
        if (p_sum == '0) begin
          acc <= acc + {{(SUM_W-LN_W){1'b1}}, MEAN_MIN};
        end
      end
      ST_SC_LOG: begin
        if (log_done) begin
          acc <= acc + {{(SUM_W-LN_W){ln_val[LN_W-1]}}, ln_val};
        end
      end
      ST_SC_NEXT: qi <= qi + 1'b1;
      ST_SC_MWAIT: begin
        mean_q   <= mean_calc;
        status_q <= dropped ? STAT_DROPPED : STAT_OK;
      end
      ST_DONE: begin
        if (out_free) begin
          scored_cell   <= cell_q;
          mean_log_prob <= mean_q;
          status        <= status_q;
        end
      end
      default: ;
    endcase
  end

  sucs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << TAW)) u_count_ram (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rd)
  );

  sucs_ram #(.WIDTH(TOTAL_W), .DEPTH(1 << CW)) u_cell_ram (
    .clk(clk), .we(ct_we), .addr(ct_addr), .wdata(ct_wdata), .rdata(ct_rd)
  );

  sucs_ram #(.WIDTH(TOTAL_W), .DEPTH(1 << WW)) u_word_ram (
    .clk(clk), .we(wt_we), .addr(wt_addr), .wdata(wt_wdata), .rdata(wt_rd)
  );

  sucs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_QUERY)) u_query_ram (
    .clk(clk), .we(q_we), .addr(q_addr), .wdata(word), .rdata(q_rd)
  );

  sucs_div #(.NUM_W(TOTAL_W), .DEN_W(TOTAL_W)) u_div_cell (
    .clk(clk), .rst(rst), .start(divc_start), .rem_init(xc), .num('0),
    .den(n_q), .done(divc_done), .quot(qc)
  );

  sucs_div #(.NUM_W(TOTAL_W), .DEN_W(TOTAL_W)) u_div_global (
    .clk(clk), .rst(rst), .start(divg_start), .rem_init(xg), .num('0),
    .den(global_total), .done(divg_done), .quot(qg)
  );

  sucs_div #(.NUM_W(SUM_W), .DEN_W(QLW)) u_div_mean (
    .clk(clk), .rst(rst), .start(mdiv_start), .rem_init('0), .num(acc_mag),
    .den(qlen), .done(mdiv_done), .quot(mquot)
  );

  sucs_log u_log (
    .clk(clk), .rst(rst), .start(log_start), .p(p_sum),
    .done(log_done), .ln(ln_val)
  );

  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    qlen <= QLW'(MAX_QUERY))
    else $error("query length beyond buffer size");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    divc_done == divg_done)
    else $error("ratio dividers out of step");

  a_mean_nonpos: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (mean_log_prob[LN_W-1] || mean_log_prob == '0))
    else $error("positive mean log probability");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status == STAT_EMPTY_QUERY || status == STAT_EMPTY_MODEL))
      |-> mean_log_prob == '0)
    else $error("empty score with nonzero value");
endmodule

// File: tb/sv/smoothed_unigram_cell_scorer_tb.sv
// Self-checking testbench for the smoothed unigram cell scorer.
`timescale 1ns / 1ps
module smoothed_unigram_cell_scorer_tb;
  import sucs_pkg::*;

  localparam int CELLS     = 2048;
  localparam int WORDS     = 1024;
  localparam int QMAX      = 64;
  localparam int CNT_MAX   = (1 << 20) - 1;
  localparam longint LN2_FIX = 64'd2977044472;
  localparam longint FLOOR_Q16 = -64'sd8388608;

  typedef struct {
    logic [1:0]  cmd;
    logic [10:0] cell_no;
    logic [9:0]  wd;
  } score_item_t;

  typedef struct {
    logic [10:0]        cell_no;
    logic signed [23:0] mlp;
    logic [1:0]         stat;
  } cell_score_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] command = CMD_TRAIN;
  logic [10:0] cell_req = '0;
  logic [9:0] word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [10:0] scored_cell;
  logic signed [23:0] mean_log_prob;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_CELL_WEIGHT;
  logic [15:0] cfg_data = '0;

  score_item_t pending_items[$];
  cell_score_t expected_scores[$];
  logic item_took = 1'b0;
  int send_gap = 0;
  int rx_gap = 0;
  int long_hold = 0;
  bit quiet = 0;
  int errors = 0;
  int n_scores = 0;
  int n_stat[4] = '{0, 0, 0, 0};

  int unsigned cnt_tab[bit [20:0]];
  bit [31:0] cell_tot[CELLS];
  bit [31:0] word_tot[WORDS];
  bit [31:0] glob_tot = 0;
  bit [9:0] qwords[QMAX];
  int qlen = 0;
  bit qdrop = 0;
  bit [15:0] cw = CELL_WEIGHT_RST;
  bit [15:0] gw = GLOBAL_WEIGHT_RST;

  smoothed_unigram_cell_scorer u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .cell_req(cell_req), .word(word),
    .res_valid(res_valid), .res_stall(res_stall),
    .scored_cell(scored_cell), .mean_log_prob(mean_log_prob), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit [63:0] ratio_q32(bit [63:0] num, bit [63:0] den);
    bit [63:0] r;
    r = (num << 32) / den;
    return (r > (64'd1 << 32)) ? (64'd1 << 32) : r;
  endfunction

  function automatic longint ln_fix(bit [63:0] p);
    int e;
    bit [63:0] m;
    longint frac, lg, prod;
    bit [63:0] mag, r;
    e = 63;
    frac = 0;
    while (e > 0 && !p[e]) e--;
    m = (e >= 30) ? (p >> (e - 30)) : (p << (30 - e));
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    lg = longint'(e - 48) * 1048576 + frac;
    prod = lg * LN2_FIX;
    mag = (prod < 0) ? -prod : prod;
    r = (mag + (64'd1 << 35)) >> 36;
    return (prod < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint word_log(bit [10:0] cell_no, bit [9:0] w);
    bit [63:0] c, n, a, g, p;
    n = 64'(cell_tot[cell_no]);
    a = 64'(word_tot[w]);
    g = 64'(glob_tot);
    c = cnt_tab.exists({cell_no, w}) ? 64'(cnt_tab[{cell_no, w}]) : 64'd0;
    if (n == 0)
      p = gw * ratio_q32((a == 0) ? 64'd1 : a, g);
    else if (c == 0 && a == 0)
      p = cw * ratio_q32(64'd1, n) + gw * ratio_q32(64'd1, g);
    else
      p = cw * ratio_q32(c, n) + gw * ratio_q32(a, g);
    if (p == 0) return FLOOR_Q16;
    return ln_fix(p);
  endfunction

  function automatic cell_score_t score_cell(bit [10:0] cell_no);
    cell_score_t s;
    longint sum, mean;
    sum = 0;
    mean = 0;
    s.cell_no = cell_no;
    if (qlen == 0) s.stat = STAT_EMPTY_QUERY;
    else if (glob_tot == 0) s.stat = STAT_EMPTY_MODEL;
    else begin
      for (int i = 0; i < qlen; i++) sum += word_log(cell_no, qwords[i]);
      mean = sum / qlen;
      if (mean < FLOOR_Q16) mean = FLOOR_Q16;
      if (mean > 0) mean = 0;
      s.stat = qdrop ? STAT_DROPPED : STAT_OK;
    end
    s.mlp = mean[23:0];
    return s;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Monitor: updates the predictor on each accepted item and checks results.
  always @(posedge clk) begin
    cell_score_t s;
    bit [20:0] key;
    item_took <= item_valid && !item_stall && !rst;
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CELL_WEIGHT) cw = cfg_data;
      else gw = cfg_data;
    end
    if (!rst && item_valid && !item_stall) begin
      case (command)
        CMD_TRAIN: begin
          key = {cell_req, word};
          if ((cnt_tab.exists(key) ? cnt_tab[key] : 0) < CNT_MAX) begin
            cnt_tab[key] = (cnt_tab.exists(key) ? cnt_tab[key] : 0) + 1;
            if (cell_tot[cell_req] != 32'hFFFF_FFFF) cell_tot[cell_req]++;
            if (word_tot[word] != 32'hFFFF_FFFF) word_tot[word]++;
            if (glob_tot != 32'hFFFF_FFFF) glob_tot++;
          end
        end
        CMD_APPEND: begin
          if (qlen < QMAX) begin
            qwords[qlen] = word;
            qlen++;
          end else qdrop = 1;
        end
        CMD_CLEAR: begin
          qlen = 0;
          qdrop = 0;
        end
        default: expected_scores.push_back(score_cell(cell_req));
      endcase
    end
    if (!rst && res_valid && !res_stall) begin
      if (expected_scores.size() == 0) begin
        report("unexpected item", 64'(scored_cell), 64'd0);
      end else begin
        s = expected_scores.pop_front();
        n_scores++;
        n_stat[s.stat]++;
        if (scored_cell !== s.cell_no)
          report("scored_cell", 64'(scored_cell), 64'(s.cell_no));
        if (mean_log_prob !== s.mlp)
          report("mean_log_prob", 64'(mean_log_prob), 64'(s.mlp));
        if (status !== s.stat) report("status", 64'(status), 64'(s.stat));
      end
    end
  end

  // Driver of the item channel.
  always @(negedge clk) begin
    score_item_t it;
    if (!rst && (!item_valid || item_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        item_valid <= 1'b1;
        command <= it.cmd;
        cell_req <= it.cell_no;
        word <= it.wd;
        if (!quiet && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 18);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      res_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      res_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 17);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic push(logic [1:0] cmd, logic [10:0] cell_no, logic [9:0] wd);
    score_item_t it;
    it.cmd = cmd;
    it.cell_no = cell_no;
    it.wd = wd;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_scores.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // One random stretch of well-formed sequences mixed with noise.
  task automatic random_phase(int budget, bit with_overflow);
    int k, n;
    logic [10:0] cells[8];
    logic [9:0] words[16];
    foreach (cells[i]) cells[i] = 11'($urandom_range(0, 2047));
    foreach (words[i]) words[i] = 10'($urandom_range(0, 1023));
    if (with_overflow) begin
      push(CMD_CLEAR, 11'($urandom), 10'($urandom));
      n = $urandom_range(65, 67);
      for (int i = 0; i < n; i++)
        push(CMD_APPEND, 11'($urandom), words[$urandom_range(0, 15)]);
      push(CMD_SCORE, cells[0], 10'($urandom));
      push(CMD_CLEAR, 11'($urandom), 10'($urandom));
      budget -= n + 3;
    end
    k = 0;
    while (k < budget) begin
      case ($urandom_range(0, 9))
        0: begin
          push(2'($urandom_range(0, 3)), 11'($urandom), 10'($urandom));
          k++;
        end
        1, 2, 3: begin
          n = $urandom_range(3, 12);
          for (int i = 0; i < n; i++) push(CMD_TRAIN, cells[$urandom_range(0, 7)],
                                           words[$urandom_range(0, 15)]);
          k += n;
        end
        default: begin
          if ($urandom_range(0, 2) != 0) begin
            push(CMD_CLEAR, 11'($urandom), 10'($urandom));
            k++;
          end
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            push(CMD_APPEND, 11'($urandom), ($urandom_range(0, 5) == 0) ? 10'($urandom) :
                 words[$urandom_range(0, 15)]);
          k += n;
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            push(CMD_SCORE, ($urandom_range(0, 4) == 0) ? 11'($urandom) :
                 cells[$urandom_range(0, 7)], 10'($urandom));
          k += n;
        end
      endcase
    end
  endtask

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_reg(REG_CELL_WEIGHT, CELL_WEIGHT_RST);
    write_reg(REG_GLOBAL_WEIGHT, GLOBAL_WEIGHT_RST);

    push(CMD_SCORE, 11'd5, 10'd0);
    push(CMD_APPEND, 11'd0, 10'd3);
    push(CMD_SCORE, 11'd5, 10'd0);
    push(CMD_TRAIN, 11'd5, 10'd3);
    push(CMD_TRAIN, 11'd5, 10'd3);
    push(CMD_TRAIN, 11'd5, 10'd7);
    push(CMD_TRAIN, 11'd2047, 10'd1023);
    push(CMD_TRAIN, 11'd0, 10'd0);
    push(CMD_APPEND, 11'd2047, 10'd512);
    push(CMD_APPEND, 11'd0, 10'd1023);
    push(CMD_APPEND, 11'd0, 10'd7);
    push(CMD_SCORE, 11'd5, 10'd1023);
    push(CMD_SCORE, 11'd2047, 10'd0);
    push(CMD_SCORE, 11'd100, 10'd0);
    push(CMD_SCORE, 11'd0, 10'd0);
    drain();

    write_reg(REG_CELL_WEIGHT, 16'd0);
    write_reg(REG_GLOBAL_WEIGHT, 16'd0);
    push(CMD_SCORE, 11'd5, 10'd0);
    push(CMD_SCORE, 11'd2047, 10'd0);
    drain();

    write_reg(REG_CELL_WEIGHT, 16'hFFFF);
    write_reg(REG_GLOBAL_WEIGHT, 16'hFFFF);
    push(CMD_SCORE, 11'd5, 10'd0);
    push(CMD_CLEAR, 11'd0, 10'd0);
    push(CMD_SCORE, 11'd5, 10'd0);
    drain();

    write_reg(REG_CELL_WEIGHT, CELL_WEIGHT_RST);
    write_reg(REG_GLOBAL_WEIGHT, GLOBAL_WEIGHT_RST);
    random_phase(70, 1'b1);
    drain();

    // The receiver holds off while several short scores are offered behind it.
    long_hold = 3000;
    for (int i = 0; i < 8; i++) push(CMD_TRAIN, 11'd5, 10'($urandom_range(0, 7)));
    push(CMD_CLEAR, 11'd0, 10'd0);
    push(CMD_APPEND, 11'd0, 10'd3);
    for (int i = 0; i < 6; i++) push(CMD_SCORE, 11'($urandom_range(0, 7)), 10'd0);
    drain();

    write_reg(REG_CELL_WEIGHT, 16'($urandom));
    write_reg(REG_GLOBAL_WEIGHT, 16'($urandom));
    random_phase(60, 1'b0);
    drain();

    write_reg(REG_CELL_WEIGHT, 16'($urandom_range(0, 4096)));
    write_reg(REG_GLOBAL_WEIGHT, 16'($urandom_range(60000, 65535)));
    random_phase(50, 1'b0);
    drain();

    quiet = 1;
    write_reg(REG_CELL_WEIGHT, CELL_WEIGHT_RST);
    write_reg(REG_GLOBAL_WEIGHT, GLOBAL_WEIGHT_RST);
    random_phase(50, 1'b0);
    drain();

    $display("Scored %0d cells: %0d ok, %0d empty query, %0d empty model, %0d dropped words.",
             n_scores, n_stat[0], n_stat[1], n_stat[2], n_stat[3]);
    $display("Weights covered zero, full scale, reset and random values; %0d mismatches.",
             errors);
    if (errors == 0 && expected_scores.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
